// File: rtl/ubds_pkg.sv
// Package for the baud divisor search: field widths, the supported rate list,
// the token that travels down the pipeline and small helper functions.
// No dependencies.
package ubds_pkg;

   localparam int unsigned BaudW   = 24;
   localparam int unsigned ClockW  = 28;
   localparam int unsigned RatioW  = 5;
   localparam int unsigned DivW    = 13;
   localparam int unsigned RateW   = 17;
   localparam int unsigned NumRates = 7;
   localparam logic [DivW-1:0] DivMax = 13'd8191;
   localparam logic [ClockW-1:0] ClockReset = 28'd8000000;

   localparam logic [RateW-1:0] Rates [NumRates] = '{
      17'd4800, 17'd9600, 17'd14400, 17'd19200, 17'd38400, 17'd57600, 17'd115200
   };

   // One candidate setting of one request.
   typedef struct packed {
      logic              first;
      logic              last;
      logic              rej;
      logic              skip;
      logic [RatioW-1:0] osr;
      logic [RateW-1:0]  baud;
      logic [DivW-1:0]   div;
   } tok_type;

   // True when the rate is one of the standard rates.
   function automatic logic rate_supported(input logic [BaudW-1:0] baud);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < NumRates; k++) begin
         if (baud == {7'd0, Rates[k]}) hit = 1'b1;
      end
      return hit;
   endfunction

   // Oversampling factor, the setting plus one.
   function automatic logic [RatioW:0] osr_factor(input logic [RatioW-1:0] osr);
      return {1'b0, osr} + 6'd1;
   endfunction

endpackage

// File: rtl/ubds_req_if.sv
// Request channel: one requested baud rate per word.
// Depends on ubds_pkg.
interface ubds_req_if;
   import ubds_pkg::*;
   logic              valid;
   logic              ready;
   logic [BaudW-1:0]  requested_baud;
   modport source (output valid, output requested_baud, input ready);
   modport sink   (input valid, input requested_baud, output ready);
endinterface

// File: rtl/ubds_rsp_if.sv
// Response channel: status, chosen ratio and divisor per word.
// Depends on ubds_pkg.
interface ubds_rsp_if;
   import ubds_pkg::*;
   logic              valid;
   logic              ready;
   logic              status;
   logic [RatioW-1:0] oversample_ratio;
   logic [DivW-1:0]   baud_divisor;
   modport source (output valid, output status, output oversample_ratio,
                   output baud_divisor, input ready);
   modport sink   (input valid, input status, input oversample_ratio,
                   input baud_divisor, output ready);
endinterface

// File: rtl/ubds_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// travels alongside. No package dependency.
module ubds_div #(
   parameter int unsigned NW = 28,
   parameter int unsigned DW = 23,
   parameter int unsigned TW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [NW-1:0] out_quo,
   output logic [TW-1:0] out_tag
);

   logic          v_ff   [NW];
   logic [DW-1:0] rem_ff [NW];
   logic [NW-1:0] num_ff [NW];
   logic [NW-1:0] quo_ff [NW];
   logic [DW-1:0] den_ff [NW];
   logic [TW-1:0] tag_ff [NW];

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic          v_prev;
      logic [DW-1:0] rem_prev;
      logic [NW-1:0] num_prev;
      logic [NW-1:0] quo_prev;
      logic [DW-1:0] den_prev;
      logic [TW-1:0] tag_prev;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW:0]   diff;
      logic [DW-1:0] rem_in;

      if (s == 0) begin : g_first
         assign v_prev   = in_valid;
         assign rem_prev = '0;
         assign num_prev = in_num;
         assign quo_prev = '0;
         assign den_prev = in_den;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign v_prev   = v_ff[s-1];
         assign rem_prev = rem_ff[s-1];
         assign num_prev = num_ff[s-1];
         assign quo_prev = quo_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign tag_prev = tag_ff[s-1];
      end

      // Bring down the next dividend bit and subtract when it fits.
      assign trial  = {rem_prev, num_prev[NW-1]};
      assign ge     = trial >= {1'b0, den_prev};
      assign diff   = trial - {1'b0, den_prev};
      assign rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            num_ff[s] <= {num_prev[NW-2:0], 1'b0};
            quo_ff[s] <= {quo_prev[NW-2:0], ge};
            den_ff[s] <= den_prev;
            tag_ff[s] <= tag_prev;
         end
      end
   end

   assign out_valid = v_ff[NW-1];
   assign out_quo   = quo_ff[NW-1];
   assign out_tag   = tag_ff[NW-1];

endmodule

// File: rtl/uart_baud_divisor_search_core.sv
// Top level of the baud divisor search core: issue stage, two pipelined
// dividers, error and best-setting stages. Depends on ubds_pkg, ubds_req_if,
// ubds_rsp_if and ubds_div.
//
// Usage: write the functional clock frequency through csr_wr_en/csr_wr_data
// while the core is idle. Each request word on req_chan carries a baud rate;
// one response word on rsp_chan gives status, oversampling setting and
// divisor. A rate outside the standard list answers with status 1 and zeros.
// Each request is expanded into one candidate per oversampling setting, or
// into a single candidate for a rejected rate; the issue stage accepts the
// next request as soon as the last candidate is out. Candidates flow
// through a multiply stage, a 28-stage divider, a second multiply stage, a
// second 28-stage divider, an error stage and a best-setting stage, and
// the response register takes its word from the last candidate. The
// response register parts the two sides; while the receiver stalls with
// a word waiting, the whole pipeline holds and nothing is lost.
// Synchronous reset empties the pipeline and sets the clock register to
// 8 MHz.
module uart_baud_divisor_search_core #(
   parameter int unsigned OSR_FIRST = 4,
   parameter int unsigned OSR_LAST  = 31
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [ubds_pkg::ClockW-1:0]   csr_wr_data,
   ubds_req_if.sink                      req_chan,
   ubds_rsp_if.source                    rsp_chan
);
   import ubds_pkg::*;

   localparam logic [RatioW-1:0] FirstR = RatioW'(OSR_FIRST);
   localparam logic [RatioW-1:0] LastR  = RatioW'(OSR_LAST);
   localparam logic              Empty  = (OSR_FIRST > OSR_LAST);
   localparam int unsigned       TokW   = $bits(tok_type);

   logic              en;
   logic [ClockW-1:0] clk_hz_ff;

   // Clock frequency register.
   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= ClockReset;
      end else if (csr_wr_en) begin
         clk_hz_ff <= csr_wr_data;
      end
   end

   // Issue stage: expands one request into its candidate settings.
   logic              busy_ff;
   logic [RatioW-1:0] r_ff;
   logic [RateW-1:0]  baud_ff;
   logic              rej_ff;
   logic              last_now;
   logic              req_take;
   tok_type           tok_in, tok_ff;
   logic              tok_v_ff;

   assign req_chan.ready = !busy_ff;
   assign req_take = req_chan.valid && !busy_ff;
   assign last_now = rej_ff || Empty || (r_ff == LastR);

   always_comb begin
      tok_in.first = (r_ff == FirstR) || rej_ff || Empty;
      tok_in.last  = last_now;
      tok_in.rej   = rej_ff;
      tok_in.skip  = Empty;
      tok_in.osr   = (rej_ff || Empty) ? '0 : r_ff;
      tok_in.baud  = baud_ff;
      tok_in.div   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         tok_v_ff <= 1'b0;
      end else begin
         if (req_take) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && en && last_now) begin
            busy_ff <= 1'b0;
         end
         if (en) tok_v_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         r_ff    <= FirstR;
         baud_ff <= req_chan.requested_baud[RateW-1:0];
         rej_ff  <= !rate_supported(req_chan.requested_baud);
      end else if (busy_ff && en && !last_now) begin
         r_ff <= r_ff + 5'd1;
      end
      if (en) tok_ff <= tok_in;
   end

   // First multiply stage: baud times oversampling factor.
   logic    b_v_ff;
   tok_type b_tok_ff;
   logic [RateW+RatioW:0] b_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= tok_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_tok_ff  <= tok_ff;
         b_prod_ff <= (RateW+RatioW+1)'(tok_ff.baud) *
                      (RateW+RatioW+1)'(osr_factor(tok_ff.osr));
      end
   end

   // Divisor = clock / (baud * factor).
   logic              d1_v;
   logic [ClockW-1:0] d1_q;
   logic [TokW-1:0]   d1_tag;
   tok_type           d1_tok;

   ubds_div #(.NW(ClockW), .DW(RateW+RatioW+1), .TW(TokW)) u_div_rate (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(b_v_ff), .in_num(clk_hz_ff), .in_den(b_prod_ff), .in_tag(b_tok_ff),
      .out_valid(d1_v), .out_quo(d1_q), .out_tag(d1_tag)
   );
   assign d1_tok = tok_type'(d1_tag);

   // Second multiply stage: range check, then divisor times factor.
   logic    c_v_ff;
   tok_type c_tok_ff, c_tok_in;
   logic [DivW+RatioW:0] c_prod_ff;
   logic    d1_bad;

   assign d1_bad = (d1_q == '0) || (d1_q > {15'd0, DivMax});

   always_comb begin
      c_tok_in      = d1_tok;
      c_tok_in.skip = d1_tok.skip || d1_bad;
      c_tok_in.div  = d1_q[DivW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en) begin
         c_v_ff <= d1_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_tok_ff      <= c_tok_in;
         c_prod_ff     <= (DivW+RatioW+1)'(d1_q[DivW-1:0]) *
                          (DivW+RatioW+1)'(osr_factor(d1_tok.osr));
      end
   end

   // Achieved rate = clock / (divisor * factor).
   logic              d2_v;
   logic [ClockW-1:0] d2_q;
   logic [TokW-1:0]   d2_tag;
   tok_type           d2_tok;

   ubds_div #(.NW(ClockW), .DW(DivW+RatioW+1), .TW(TokW)) u_div_achieved (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(c_v_ff), .in_num(clk_hz_ff), .in_den(c_prod_ff), .in_tag(c_tok_ff),
      .out_valid(d2_v), .out_quo(d2_q), .out_tag(d2_tag)
   );
   assign d2_tok = tok_type'(d2_tag);

   // Error stage: absolute difference to the requested rate.
   logic              e_v_ff;
   tok_type           e_tok_ff;
   logic [ClockW-1:0] e_err_ff;
   logic [ClockW-1:0] baud_wide;

   assign baud_wide = {11'd0, d2_tok.baud};

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (en) begin
         e_v_ff <= d2_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_tok_ff <= d2_tok;
         e_err_ff <= (d2_q >= baud_wide) ? (d2_q - baud_wide) : (baud_wide - d2_q);
      end
   end

   // Best-setting stage; a later setting wins a tie.
   logic [ClockW-1:0] best_err_ff, cur_err, best_err_in;
   logic [RatioW-1:0] best_r_ff, cur_r, best_r_in;
   logic [DivW-1:0]   best_div_ff, cur_div, best_div_in;
   logic              take;

   always_comb begin
      cur_err = e_tok_ff.first ? {11'd0, e_tok_ff.baud} : best_err_ff;
      cur_r   = e_tok_ff.first ? '0 : best_r_ff;
      cur_div = e_tok_ff.first ? '0 : best_div_ff;
      take    = !e_tok_ff.skip && !e_tok_ff.rej && (e_err_ff <= cur_err);
      best_err_in = take ? e_err_ff : cur_err;
      best_r_in   = take ? e_tok_ff.osr : cur_r;
      best_div_in = take ? e_tok_ff.div : cur_div;
   end

   always_ff @(posedge clock) begin
      if (en && e_v_ff) begin
         best_err_ff <= best_err_in;
         best_r_ff   <= best_r_in;
         best_div_ff <= best_div_in;
      end
   end

   // Response register.
   logic              rsp_v_ff;
   logic              rsp_status_ff;
   logic [RatioW-1:0] rsp_r_ff;
   logic [DivW-1:0]   rsp_div_ff;
   logic              emit;

   assign en   = !rsp_v_ff || rsp_chan.ready;
   assign emit = e_v_ff && e_tok_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         rsp_v_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (en && emit) begin
         rsp_status_ff <= e_tok_ff.rej;
         rsp_r_ff      <= best_r_in;
         rsp_div_ff    <= best_div_in;
      end
   end

   assign rsp_chan.valid            = rsp_v_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.oversample_ratio = rsp_r_ff;
   assign rsp_chan.baud_divisor     = rsp_div_ff;

   // A rejected rate never carries a setting.
   a_rej_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_status_ff) |-> (rsp_r_ff == '0 && rsp_div_ff == '0))
      else $error("rejected rate reports a nonzero setting");

   // A chosen divisor comes with a setting inside the searched range.
   a_osr_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_div_ff != '0) |-> (rsp_r_ff >= FirstR && rsp_r_ff <= LastR))
      else $error("chosen setting outside the searched range");

   // An accepted request keeps the issue stage busy next cycle.
   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> busy_ff)
      else $error("issue stage idle after accepting a request");

   // A stalled pipeline issues nothing new.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!en && busy_ff) |=> $stable(r_ff))
      else $error("candidate advanced during a stall");

endmodule

// File: bench/uart_baud_divisor_search_core_tb.sv
// Testbench for the baud divisor search core: drives baud requests through the
// request interface, predicts each response and compares it word by word.
// Depends on ubds_pkg, ubds_req_if, ubds_rsp_if and the core itself.
module uart_baud_divisor_search_core_tb;
   import ubds_pkg::*;

   typedef struct packed {
      logic              status;
      logic [RatioW-1:0] ratio;
      logic [DivW-1:0]   divisor;
   } answer_type;

   localparam int unsigned OsrLo = 4;
   localparam int unsigned OsrHi = 31;
   localparam int unsigned SettleCycles = 150;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [ClockW-1:0] csr_wr_data;

   ubds_req_if req_chan ();
   ubds_rsp_if rsp_chan ();

   uart_baud_divisor_search_core #(.OSR_FIRST(OsrLo), .OSR_LAST(OsrHi)) uut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   logic [ClockW-1:0] clock_hz;
   logic [BaudW-1:0]  pending_bauds [$];
   answer_type        expected_answers [$];
   int                error_count = 0;
   logic              hold_go = 1'b0;
   logic              hold_active;
   logic              req_accepted;
   int                req_gap;
   int                rsp_gap;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Predict the chosen setting for one request.
   function automatic answer_type search_divisor(input logic [BaudW-1:0] baud,
                                                 input logic [ClockW-1:0] clk_hz);
      answer_type  ans;
      logic [63:0] best_err;
      logic [63:0] div;
      logic [63:0] achieved;
      logic [63:0] err;
      logic        listed;
      ans = '0;
      listed = 1'b0;
      foreach (Rates[k]) if (baud == BaudW'(Rates[k])) listed = 1'b1;
      if (!listed) begin
         ans.status = 1'b1;
         return ans;
      end
      best_err = 64'(baud);
      for (int r = OsrLo; r <= OsrHi; r++) begin
         div = 64'(clk_hz) / (64'(baud) * 64'(r + 1));
         if (div == 0 || div > 64'(DivMax)) continue;
         achieved = 64'(clk_hz) / (div * 64'(r + 1));
         err = (achieved >= 64'(baud)) ? achieved - 64'(baud) : 64'(baud) - achieved;
         if (err <= best_err) begin
            best_err = err;
            ans.ratio = RatioW'(r);
            ans.divisor = DivW'(div);
         end
      end
      return ans;
   endfunction

   // Driver: offer queued words with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.requested_baud <= '0;
         req_gap <= 0;
      end else if (req_chan.valid && !req_accepted) begin
         // Hold the word until it is taken.
      end else if (req_gap > 0) begin
         req_chan.valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_bauds.size() > 0) begin
         req_chan.valid <= 1'b1;
         req_chan.requested_baud <= pending_bauds.pop_front();
         req_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // Predict at acceptance so each word uses the clock setting in force.
   always @(posedge clock) begin
      req_accepted <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         expected_answers.push_back(search_divisor(req_chan.requested_baud, clock_hz));
      end
   end

   // Long receiver hold-off, counted in cycles once requested.
   initial begin
      hold_active = 1'b0;
      wait (hold_go);
      @(posedge clock);
      hold_active = 1'b1;
      repeat (600) @(posedge clock);
      hold_active = 1'b0;
   end

   // Receiver readiness with random stalls and one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= 0;
      end else if (hold_active) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         rsp_gap <= $urandom_range(0, 2) == 0 ? $urandom_range(0, 15) : 0;
      end
   end

   // Monitor: compare each response word with the oldest prediction.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_answers.size() == 0) begin
            error_count <= error_count + 1;
            if (error_count < 10) $display("Unexpected response word");
         end else begin
            want = expected_answers.pop_front();
            if (rsp_chan.status !== want.status || rsp_chan.oversample_ratio !== want.ratio
                || rsp_chan.baud_divisor !== want.divisor) begin
               error_count <= error_count + 1;
               if (error_count < 10)
                  $display("Mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                           want.status, want.ratio, want.divisor, rsp_chan.status,
                           rsp_chan.oversample_ratio, rsp_chan.baud_divisor);
            end
         end
      end
   end

   // Wait until every word is sent and answered, then let the pipeline settle.
   task automatic drain();
      while (pending_bauds.size() > 0 || req_chan.valid || expected_answers.size() > 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_clock_hz(input logic [ClockW-1:0] hz);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= hz;
      clock_hz <= hz;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [BaudW-1:0] random_baud();
      case ($urandom_range(0, 9))
         0: return BaudW'($urandom);
         1: return BaudW'(Rates[$urandom_range(0, NumRates - 1)] + 1);
         default: return BaudW'(Rates[$urandom_range(0, NumRates - 1)]);
      endcase
   endfunction

   initial begin
      logic [ClockW-1:0] clocks [8];
      clocks = '{28'd8000000, 28'd1, 28'hFFFFFFF, 28'd200000000, 28'd48000000,
                 28'd0, 28'd100000, 28'd24000000};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      clock_hz = ClockReset;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words at the reset clock: every listed rate and the field extremes.
      foreach (Rates[k]) pending_bauds.push_back(BaudW'(Rates[k]));
      pending_bauds.push_back('0);
      pending_bauds.push_back('1);
      pending_bauds.push_back(BaudW'(4799));
      pending_bauds.push_back(BaudW'(115201));
      pending_bauds.push_back(24'hAAAAAA);
      pending_bauds.push_back(24'h555555);
      drain();

      // Random words across several clock settings, extremes among them.
      foreach (clocks[c]) begin
         set_clock_hz(c == 0 ? clocks[c] : (c == 7 ? ClockW'($urandom) : clocks[c]));
         for (int n = 0; n < 160; n++) pending_bauds.push_back(random_baud());
         if (c == 3) hold_go = 1'b1;
         drain();
      end
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #30000000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
